// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and link types for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int GROUP       = 8;
  localparam int NUM_GROUPS  = (WINDOW_MAX + GROUP - 1) / GROUP;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Travels left to right: raw cell contents and contents after removal.
  typedef struct packed {
    sample_t c;
    logic    le;
    sample_t d;
    logic    dle;
    logic    dvld;
  } cell_fwd_t;

  // Travels right to left: raw cell contents.
  typedef struct packed {
    sample_t c;
    logic    vld;
    logic    le;
  } cell_bwd_t;

endpackage

// ===== hdl/swm_history.sv =====
// ----------------------------------------------------------------------------
// swm_history
// Arrival-order sample store with a registered read port and write bypass.
// ----------------------------------------------------------------------------
module swm_history (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [swm_pkg::PTR_W-1:0] wr_addr_i,
  input  swm_pkg::sample_t         wr_data_i,
  input  logic [swm_pkg::PTR_W-1:0] rd_addr_i,
  output swm_pkg::sample_t         rd_data_o
);

  swm_pkg::sample_t mem [swm_pkg::WINDOW_MAX];
  swm_pkg::sample_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Forward a same-cycle write so the read always sees current contents.
  always_ff @(posedge clk_i) begin
    if (we_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hdl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: removes one copy of the retired sample and
// inserts the new one using only its own and its neighbors' contents.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               upd_i,
  input  logic               del_i,
  input  logic               sel_i,
  input  swm_pkg::sample_t   sample_i,
  input  swm_pkg::sample_t   old_i,
  input  swm_pkg::cell_fwd_t from_left_i,
  input  swm_pkg::cell_bwd_t from_right_i,
  output swm_pkg::cell_fwd_t to_right_o,
  output swm_pkg::cell_bwd_t to_left_o,
  output swm_pkg::sample_t   cand_o
);

  swm_pkg::sample_t val_q, val_d;
  logic             vld_q, vld_d;
  logic             le_own, ge_old, shift;
  swm_pkg::sample_t d_val, ins_val;
  logic             d_vld, d_le;

  always_comb begin
    le_own = vld_q && (val_q <= sample_i);
    ge_old = !vld_q || (val_q >= old_i);
    shift  = del_i && ge_old;

    // contents after the retired copy is dropped
    d_val = shift ? from_right_i.c   : val_q;
    d_vld = shift ? from_right_i.vld : vld_q;
    d_le  = shift ? from_right_i.le  : le_own;

    // insert the new sample into the reduced row
    if (d_le) begin
      val_d = d_val;
      vld_d = d_vld;
    end else if (from_left_i.dle) begin
      val_d = sample_i;
      vld_d = 1'b1;
    end else begin
      val_d = from_left_i.d;
      vld_d = from_left_i.dvld;
    end

    // contents after insertion alone, for the median pick
    if (le_own) begin
      ins_val = val_q;
    end else if (from_left_i.le) begin
      ins_val = sample_i;
    end else begin
      ins_val = from_left_i.c;
    end
  end

  assign to_right_o = '{c: val_q, le: le_own, d: d_val, dle: d_le, dvld: d_vld};
  assign to_left_o  = '{c: val_q, vld: vld_q, le: le_own};
  assign cand_o     = sel_i ? ins_val : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clr_i) begin
      vld_q <= 1'b0;
    end else if (upd_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      val_q <= val_d;
    end
  end

endmodule

// ===== hdl/sliding_window_median.sv =====
// Output path: a sample that completes a window has its median registered in
//   grp_q and then in out_q, which drives it onto m_axis.
// Throughput: one sample per cycle. The input stalls only while a held-off sink
//   leaves two medians waiting.
// Reset: empty window, window length 1. A length write also empties the window.
// ----------------------------------------------------------------------------
// sliding_window_median
// Running lower median over the newest window_length samples, built as a row
// of sorting cells plus an arrival-order history memory.
// ----------------------------------------------------------------------------
module sliding_window_median (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // s_axis_tdata: [31:0] sample
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] s_axis_tdata,
  // m_axis_tdata: [31:0] median
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [swm_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swm_pkg::LEN_W-1:0]    cfg_data_i
);

  localparam int N = swm_pkg::WINDOW_MAX;
  localparam int G = swm_pkg::GROUP;
  localparam int NG = swm_pkg::NUM_GROUPS;
  localparam int CW = swm_pkg::CNT_W;
  localparam int PW = swm_pkg::PTR_W;

  logic          cfg_we, accept, full_now, emit, upd, del;
  logic [CW-1:0] len_q, len_d, fill_q, fill_d, med_idx;
  logic [PW-1:0] oldest_q, oldest_d, wr_addr;
  logic [PW:0]   wr_sum;
  logic          sel_q [N];
  logic          sel_d [N];

  swm_pkg::sample_t   sample, old_val;
  swm_pkg::cell_fwd_t fwd [N+1];
  swm_pkg::cell_bwd_t bwd [N+1];
  swm_pkg::sample_t   cand [NG*G];
  swm_pkg::sample_t   grp_d [NG];
  swm_pkg::sample_t   grp_q [NG];
  swm_pkg::sample_t   out_d, out_q;
  logic               st1_vld_q, out_vld_q, advance;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign sample      = swm_pkg::sample_t'(s_axis_tdata);
  assign advance     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !st1_vld_q || advance;
  assign accept      = s_axis_tvalid && s_axis_tready;

  assign full_now = (fill_q == (len_q - CW'(1)));
  assign emit     = accept && full_now;
  // a window of one never holds anything between beats
  assign upd      = accept && (len_q != CW'(1));
  assign del      = full_now;

  // clamp the written length to 1..WINDOW_MAX
  always_comb begin
    if (cfg_data_i == '0) begin
      len_d = CW'(1);
    end else if (int'(cfg_data_i) > N) begin
      len_d = CW'(N);
    end else begin
      len_d = CW'(cfg_data_i);
    end
    med_idx = (len_d - CW'(1)) >> 1;
    for (int i = 0; i < N; i++) begin
      sel_d[i] = (CW'(i) == med_idx);
    end
  end

  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (cfg_we) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (accept) begin
      if (full_now) begin
        oldest_d = (oldest_q == PW'(N - 1)) ? '0 : oldest_q + PW'(1);
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  assign wr_sum  = {1'b0, oldest_q} + (PW+1)'(fill_q);
  assign wr_addr = (wr_sum >= (PW+1)'(N)) ? PW'(wr_sum - (PW+1)'(N)) : PW'(wr_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= CW'(1);
      fill_q   <= '0;
      oldest_q <= '0;
      for (int i = 0; i < N; i++) begin
        sel_q[i] <= (i == 0);
      end
    end else begin
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      if (cfg_we) begin
        len_q <= len_d;
        sel_q <= sel_d;
      end
    end
  end

  swm_history u_history (
    .clk_i     (clk_i),
    .we_i      (accept),
    .wr_addr_i (wr_addr),
    .wr_data_i (sample),
    .rd_addr_i (oldest_d),
    .rd_data_o (old_val)
  );

  assign fwd[0] = '{c: '0, le: 1'b1, d: '0, dle: 1'b1, dvld: 1'b1};
  assign bwd[N] = '{c: '0, vld: 1'b0, le: 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clr_i        (cfg_we),
      .upd_i        (upd),
      .del_i        (del),
      .sel_i        (sel_q[i]),
      .sample_i     (sample),
      .old_i        (old_val),
      .from_left_i  (fwd[i]),
      .from_right_i (bwd[i+1]),
      .to_right_o   (fwd[i+1]),
      .to_left_o    (bwd[i]),
      .cand_o       (cand[i])
    );
  end

  for (genvar i = N; i < NG*G; i++) begin : g_pad
    assign cand[i] = '0;
  end

  // two-level OR tree picks the one selected candidate
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < G; k++) begin
        grp_d[g] = grp_d[g] | cand[g*G + k];
      end
    end
    out_d = '0;
    for (int g = 0; g < NG; g++) begin
      out_d = out_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        st1_vld_q <= emit;
      end else if (advance) begin
        st1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= st1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q <= grp_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sliding_window_median. A scoreboard class keeps its
// own history and sorted copy of the window and predicts the lower median
// of every full window. Phases at several window lengths, the limits among
// them, run with random gaps on both stream sides. One long sink hold-off
// backs the filter up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = swm_pkg::SAMPLE_BITS;
  localparam int LEN_W       = swm_pkg::LEN_W;
  localparam int WINDOW_MAX  = swm_pkg::WINDOW_MAX;

  typedef swm_pkg::sample_t sample_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned SETTLE      = 8;

  localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  class median_scoreboard;
    sample_t     arrival_q[$];
    sample_t     sorted_q[$];
    sample_t     median_q[$];
    int unsigned span;
    int unsigned errors;

    function new();
      span   = 1;
      errors = 0;
    endfunction

    // A length write also empties the window.
    function void set_length(logic [LEN_W-1:0] len);
      if (len == 0) span = 1;
      else if (len > WINDOW_MAX) span = WINDOW_MAX;
      else span = len;
      arrival_q.delete();
      sorted_q.delete();
    endfunction

    function void note_sample(sample_t s);
      int unsigned idx;
      sample_t     oldest;
      arrival_q = {arrival_q, s};
      idx = 0;
      while (idx < sorted_q.size() && sorted_q[idx] <= s) idx++;
      sorted_q.insert(idx, s);
      if (arrival_q.size() == span) begin
        median_q = {median_q, sorted_q[(span - 1) / 2]};
        // retire one copy of the oldest value
        oldest = arrival_q[0];
        arrival_q.delete(0);
        idx = 0;
        while (sorted_q[idx] != oldest) idx++;
        sorted_q.delete(idx);
      end
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (median_q.size() == 0) begin
        $display("%0t: unexpected median beat, expected none, got %0d", $time, got);
        errors++;
      end else begin
        want = median_q[0];
        median_q.delete(0);
        if (got !== want) begin
          $display("%0t: median mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return median_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [LEN_W-1:0]       cfg_data_i;

  median_scoreboard sb;
  int unsigned      cycles;
  bit               long_hold_req;

  sliding_window_median u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Note accepted samples before checking medians of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(sample_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_median(sample_t'(m_axis_tdata));
    end
  end

  initial begin : median_sink
    int unsigned hold_cycles;
    int unsigned beats;
    bit          lazy;
    bit          long_hold_done;
    beats          = 0;
    lazy           = 1'b0;
    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (beats % 20 == 0) lazy = bit'($urandom_range(0, 1));
      hold_cycles = lazy ? $urandom_range(0, 14) : 0;
      if (long_hold_req && !long_hold_done) begin
        hold_cycles    = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beats++;
    end
  end

  task automatic send_sample(input sample_t v, input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait out every expected median, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_length(len);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned count,
                           input bit fast);
    bit lazy;
    lazy = 1'b0;
    write_length(len);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 20 == 0) lazy = fast ? 1'b0 : bit'($urandom_range(0, 1));
      send_sample(rand_sample(), lazy ? $urandom_range(0, 14) : 0);
    end
    drain();
  endtask

  initial begin : stimulus
    sb            = new();
    long_hold_req = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length is one: every sample is its own median.
    send_sample(S_MIN, 0);
    send_sample(S_MAX, 0);
    send_sample('0, 1);
    send_sample('1, 0);
    drain();

    // Zero length acts as a window of one.
    write_length('0);
    send_sample(sample_t'(1), 0);
    send_sample(S_MAX, 2);
    drain();

    // Equal samples: retire exactly one copy.
    write_length(LEN_W'(3));
    send_sample(sample_t'(7), 0);
    send_sample(sample_t'(7), 0);
    send_sample(sample_t'(-3), 0);
    send_sample(sample_t'(7), 3);
    send_sample(S_MIN, 0);
    send_sample(S_MAX, 0);
    send_sample(sample_t'(7), 0);
    send_sample(sample_t'(7), 0);
    drain();

    // A length write on a partly filled window empties it.
    write_length(LEN_W'(5));
    send_sample(sample_t'(100), 0);
    send_sample(sample_t'(-100), 0);
    send_sample(S_MAX, 0);
    drain();
    write_length(LEN_W'(2));
    send_sample(sample_t'(10), 0);
    send_sample(S_MIN, 0);
    send_sample(S_MAX, 0);
    send_sample('1, 0);
    drain();

    run_phase(LEN_W'(WINDOW_MAX), 70, 1'b0);
    run_phase('1, 70, 1'b0);
    run_phase(LEN_W'(WINDOW_MAX + 1), 70, 1'b0);
    // Hold the sink off while samples keep coming so the input backs up.
    long_hold_req = 1'b1;
    run_phase(LEN_W'(2), 30, 1'b1);
    run_phase(LEN_W'(1), 30, 1'b0);
    run_phase(LEN_W'(4), 30, 1'b0);
    run_phase(LEN_W'(9), 30, 1'b0);
    run_phase(LEN_W'($urandom_range(1, WINDOW_MAX)), 30, 1'b0);
    run_phase(LEN_W'($urandom_range(0, 127)), 30, 1'b0);
    run_phase(LEN_W'(33), 30, 1'b0);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sliding_window_median.f =====
hdl/swm_pkg.sv
hdl/swm_history.sv
hdl/swm_cell.sv
hdl/sliding_window_median.sv
verif/tb.sv
